// ===== rtl/core/mtx_pkg.sv =====
`default_nettype none
package mtx_pkg;

  // Elements per matrix
  localparam int unsigned NumElem = 9;

  // Cofactor k = e[a]*e[b] - e[c]*e[d], sign folded in; column-major order
  localparam int unsigned CofIdx [NumElem][4] = '{
    '{4, 8, 7, 5}, '{5, 6, 3, 8}, '{3, 7, 6, 4},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{6, 1, 0, 7},
    '{1, 5, 2, 4}, '{3, 2, 0, 5}, '{0, 4, 3, 1}
  };

  // Cycles through the cofactor and determinant stages
  localparam int unsigned CofLatency = 4;

endpackage
`default_nettype wire

// ===== rtl/core/mtx_if.sv =====
`default_nettype none
// Input channel: one matrix per request
interface mtx_in_if #(
  parameter int unsigned WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] in_e0;
  logic signed [WORD_BITS-1:0] in_e1;
  logic signed [WORD_BITS-1:0] in_e2;
  logic signed [WORD_BITS-1:0] in_e3;
  logic signed [WORD_BITS-1:0] in_e4;
  logic signed [WORD_BITS-1:0] in_e5;
  logic signed [WORD_BITS-1:0] in_e6;
  logic signed [WORD_BITS-1:0] in_e7;
  logic signed [WORD_BITS-1:0] in_e8;

  modport source (
    output valid, in_e0, in_e1, in_e2, in_e3, in_e4, in_e5, in_e6, in_e7, in_e8,
    input  ready
  );
  modport sink (
    input  valid, in_e0, in_e1, in_e2, in_e3, in_e4, in_e5, in_e6, in_e7, in_e8,
    output ready
  );
endinterface

// Output channel: one normal matrix per request
interface mtx_out_if #(
  parameter int unsigned WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] out_e0;
  logic signed [WORD_BITS-1:0] out_e1;
  logic signed [WORD_BITS-1:0] out_e2;
  logic signed [WORD_BITS-1:0] out_e3;
  logic signed [WORD_BITS-1:0] out_e4;
  logic signed [WORD_BITS-1:0] out_e5;
  logic signed [WORD_BITS-1:0] out_e6;
  logic signed [WORD_BITS-1:0] out_e7;
  logic signed [WORD_BITS-1:0] out_e8;
  logic                        singular;

  modport source (
    output valid, out_e0, out_e1, out_e2, out_e3, out_e4, out_e5, out_e6, out_e7,
           out_e8, singular,
    input  ready
  );
  modport sink (
    input  valid, out_e0, out_e1, out_e2, out_e3, out_e4, out_e5, out_e6, out_e7,
           out_e8, singular,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/matrix_3x3_inverse_transpose.sv =====
`default_nettype none
// Channel | Dir | Payload                         | Request
// in_i    | in  | in_e0..in_e8, WORD_BITS signed   | one 3x3 matrix, column-major
// out_o   | out | out_e0..out_e8, singular         | cofactors over determinant
//
// One matrix per cycle while the output is not stalled; four cofactor and
// determinant stages, WORD_BITS + 2 divider stages per lane, output register.
// The divider, one restoring stage per quotient bit, sets the depth.
// Reset clears only the valid flags. A stall at the output holds every stage.
module matrix_3x3_inverse_transpose
  import mtx_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mtx_in_if.sink    in_i,
  mtx_out_if.source out_o
);

  localparam int unsigned CofW   = 2 * WORD_BITS + 1;
  localparam int unsigned DetW   = 3 * WORD_BITS + 3;
  localparam int unsigned LaneLat = WORD_BITS + 2;
  localparam int unsigned Lat    = CofLatency + LaneLat + 1;

  logic                        en;
  logic signed [WORD_BITS-1:0] elem [NumElem];
  logic signed [CofW-1:0]      cof  [NumElem];
  logic signed [DetW-1:0]      det;
  logic [WORD_BITS-1:0]        quot [NumElem];
  logic [Lat-1:0]              vld_q;
  logic                        sing_q [LaneLat];
  logic [WORD_BITS-1:0]        res_q  [NumElem];
  logic                        res_sing_q;

  // Whole pipeline advances unless the output request is held
  assign en         = !vld_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;

  assign elem[0] = in_i.in_e0;
  assign elem[1] = in_i.in_e1;
  assign elem[2] = in_i.in_e2;
  assign elem[3] = in_i.in_e3;
  assign elem[4] = in_i.in_e4;
  assign elem[5] = in_i.in_e5;
  assign elem[6] = in_i.in_e6;
  assign elem[7] = in_i.in_e7;
  assign elem[8] = in_i.in_e8;

  mtx_cofactor #(
    .WORD_BITS (WORD_BITS)
  ) u_cofactor (
    .clk_i  (clk_i),
    .en_i   (en),
    .elem_i (elem),
    .cof_o  (cof),
    .det_o  (det)
  );

  // One divider lane per element
  for (genvar k = 0; k < NumElem; k++) begin : g_lane
    mtx_div_lane #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .cof_i  (cof[k]),
      .det_i  (det),
      .quot_o (quot[k])
    );
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  // Singular flag alongside the lanes, then the merged output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[0] <= (det == '0);
      for (int i = 1; i < LaneLat; i++) begin
        sing_q[i] <= sing_q[i-1];
      end
      for (int k = 0; k < NumElem; k++) begin
        res_q[k] <= sing_q[LaneLat-1] ? '0 : quot[k];
      end
      res_sing_q <= sing_q[LaneLat-1];
    end
  end

  assign out_o.valid    = vld_q[Lat-1];
  assign out_o.out_e0   = res_q[0];
  assign out_o.out_e1   = res_q[1];
  assign out_o.out_e2   = res_q[2];
  assign out_o.out_e3   = res_q[3];
  assign out_o.out_e4   = res_q[4];
  assign out_o.out_e5   = res_q[5];
  assign out_o.out_e6   = res_q[6];
  assign out_o.out_e7   = res_q[7];
  assign out_o.out_e8   = res_q[8];
  assign out_o.singular = res_sing_q;

endmodule
`default_nettype wire

// ===== rtl/core/mtx_cofactor.sv =====
`default_nettype none
module mtx_cofactor
  import mtx_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned CofW = 2 * WORD_BITS + 1,
  localparam int unsigned DetW = 3 * WORD_BITS + 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic signed [WORD_BITS-1:0] elem_i [NumElem],
  output logic signed [CofW-1:0]           cof_o  [NumElem],
  output logic signed [DetW-1:0]           det_o
);

  localparam int unsigned ProdW = 2 * WORD_BITS;
  localparam int unsigned PartW = 2 * WORD_BITS + 1;

  logic signed [ProdW-1:0]     prod_a_q [NumElem];
  logic signed [ProdW-1:0]     prod_b_q [NumElem];
  logic signed [WORD_BITS-1:0] e1_q     [3];
  logic signed [WORD_BITS-1:0] e2_q     [3];
  logic signed [CofW-1:0]      cof2_q   [NumElem];
  logic signed [CofW-1:0]      cof3_q   [NumElem];
  logic signed [CofW-1:0]      cof4_q   [NumElem];
  logic signed [PartW-1:0]     part_h_q [3];
  logic signed [PartW-1:0]     part_l_q [3];
  logic signed [DetW-1:0]      det_d;
  logic signed [DetW-1:0]      det_q;

  // Determinant from split partial products
  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + (DetW'(part_h_q[k]) <<< WORD_BITS) + DetW'(part_l_q[k]);
    end
  end

  // Four stages: products, cofactors, det partials, det sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NumElem; k++) begin
        prod_a_q[k] <= ProdW'(elem_i[CofIdx[k][0]]) * ProdW'(elem_i[CofIdx[k][1]]);
        prod_b_q[k] <= ProdW'(elem_i[CofIdx[k][2]]) * ProdW'(elem_i[CofIdx[k][3]]);
        cof2_q[k]   <= CofW'(prod_a_q[k]) - CofW'(prod_b_q[k]);
        cof3_q[k]   <= cof2_q[k];
        cof4_q[k]   <= cof3_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        e1_q[k]     <= elem_i[k];
        e2_q[k]     <= e1_q[k];
        part_h_q[k] <= PartW'(e2_q[k]) *
                       PartW'($signed(cof2_q[k][CofW-1:WORD_BITS]));
        part_l_q[k] <= PartW'(e2_q[k]) *
                       PartW'($signed({1'b0, cof2_q[k][WORD_BITS-1:0]}));
      end
      det_q <= det_d;
    end
  end

  assign cof_o = cof4_q;
  assign det_o = det_q;

endmodule
`default_nettype wire

// ===== rtl/core/mtx_div_lane.sv =====
`default_nettype none
module mtx_div_lane
  import mtx_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned CofW = 2 * WORD_BITS + 1,
  localparam int unsigned DetW = 3 * WORD_BITS + 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [CofW-1:0] cof_i,
  input  wire logic signed [DetW-1:0] det_i,
  output logic [WORD_BITS-1:0]      quot_o
);

  localparam int unsigned NumA = CofW + 2 * FRAC_BITS + 1;
  localparam int unsigned NumW = ((NumA > DetW) ? NumA : DetW) + 1;

  logic [CofW-1:0]      cof_abs;
  logic [DetW-1:0]      det_abs;
  logic [NumW-1:0]      num_d;
  logic [NumW-1:0]      den_d;

  logic [NumW-1:0]      rem_q  [WORD_BITS+1];
  logic [NumW-1:0]      den_q  [WORD_BITS+1];
  logic [WORD_BITS-1:0] acc_q  [WORD_BITS+1];
  logic                 neg_q  [WORD_BITS+1];
  logic                 big_q  [WORD_BITS+1];
  logic [WORD_BITS-1:0] lim;
  logic [WORD_BITS-1:0] mag;
  logic [WORD_BITS-1:0] quot_q;

  // Rounded quotient: (|C| << 2F+1 + |D|) / (2|D|)
  always_comb begin
    cof_abs = cof_i[CofW-1] ? CofW'(-cof_i) : CofW'(cof_i);
    det_abs = det_i[DetW-1] ? DetW'(-det_i) : DetW'(det_i);
    num_d   = (NumW'(cof_abs) << (2 * FRAC_BITS + 1)) + NumW'(det_abs);
    den_d   = NumW'(det_abs) << 1;
  end

  // Saturation at the signed word limit
  always_comb begin
    lim = neg_q[WORD_BITS] ? (WORD_BITS'(1) << (WORD_BITS - 1))
                           : ((WORD_BITS'(1) << (WORD_BITS - 1)) - WORD_BITS'(1));
    mag = acc_q[WORD_BITS];
    if (big_q[WORD_BITS] || (mag > lim)) begin
      mag = lim;
    end
  end

  // Set-up stage, one restoring stage per quotient bit, then the sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_d;
      den_q[0] <= den_d;
      acc_q[0] <= '0;
      neg_q[0] <= cof_i[CofW-1] ^ det_i[DetW-1];
      big_q[0] <= (num_d >> WORD_BITS) >= den_d;
      for (int i = 1; i <= WORD_BITS; i++) begin
        if ((rem_q[i-1] >> (WORD_BITS - i)) >= den_q[i-1]) begin
          rem_q[i] <= rem_q[i-1] - (den_q[i-1] << (WORD_BITS - i));
          acc_q[i] <= {acc_q[i-1][WORD_BITS-2:0], 1'b1};
        end else begin
          rem_q[i] <= rem_q[i-1];
          acc_q[i] <= {acc_q[i-1][WORD_BITS-2:0], 1'b0};
        end
        den_q[i] <= den_q[i-1];
        neg_q[i] <= neg_q[i-1];
        big_q[i] <= big_q[i-1];
      end
      quot_q <= neg_q[WORD_BITS] ? (~mag + WORD_BITS'(1)) : mag;
    end
  end

  assign quot_o = quot_q;

endmodule
`default_nettype wire
